FILE: hdl/fds_pkg.sv
// ----------------------------------------------------------------------------
// fds_pkg
// Shared constants for the fall detection state machine: phase codes,
// configuration register indexes, field widths, item function codes, counter limits and fixed-point references.
// ----------------------------------------------------------------------------
package fds_pkg;

   localparam int PHASE_W = 3;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [PHASE_W-1:0] PH_NORMAL   = 3'd0;
   localparam logic [PHASE_W-1:0] PH_FREEFALL = 3'd1;
   localparam logic [PHASE_W-1:0] PH_IMPACT   = 3'd2;
   localparam logic [PHASE_W-1:0] PH_POSTURE  = 3'd3;
   localparam logic [PHASE_W-1:0] PH_DETECTED = 3'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_FREEFALL_THR  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMPACT_THR    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GYRO_PEAK_MIN = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_POSTURE_ANGLE = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_STILL_THR     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_FREEFALL_TMO  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_IMPACT_WIN    = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_POSTURE_TMO   = 3'd7;

   localparam logic [15:0] ONE_G_Q12 = 16'd4096;

   localparam logic       FUNC_SAMPLE = 1'b0;
   localparam logic       FUNC_CLEAR  = 1'b1;

   localparam logic [3:0] FREEFALL_CNT_MAX = 4'd15;
   localparam logic [7:0] POSTURE_CNT_MAX  = 8'd255;

endpackage

FILE: hdl/fds_req_if.sv
// ----------------------------------------------------------------------------
// fds_req_if
// Valid/ready channel carrying one sensor sample or clear item.
// ----------------------------------------------------------------------------
interface fds_req_if;
   logic        valid;
   logic        ready;
   logic        func;
   logic [15:0] accel_magnitude;
   logic signed [15:0] gyro_x;
   logic signed [15:0] gyro_y;
   logic signed [15:0] gyro_z;
   logic signed [15:0] roll_angle;
   logic signed [15:0] pitch_angle;
   logic [31:0] time_ms;

   modport source (
      output valid, func, accel_magnitude, gyro_x, gyro_y, gyro_z,
             roll_angle, pitch_angle, time_ms,
      input  ready
   );

   modport sink (
      input  valid, func, accel_magnitude, gyro_x, gyro_y, gyro_z,
             roll_angle, pitch_angle, time_ms,
      output ready
   );
endinterface

FILE: hdl/fds_rsp_if.sv
// ----------------------------------------------------------------------------
// fds_rsp_if
// Valid/ready channel carrying one detector result per item.
// ----------------------------------------------------------------------------
interface fds_rsp_if;
   logic       valid;
   logic       ready;
   logic       fall_detected;
   logic [2:0] phase;

   modport source (
      output valid, fall_detected, phase,
      input  ready
   );

   modport sink (
      input  valid, fall_detected, phase,
      output ready
   );
endinterface

FILE: hdl/fall_detection_fsm.sv
// ----------------------------------------------------------------------------
// fall_detection_fsm
// Threshold fall detector. Takes one item per clock while the result side
// does not stall. The input transfer loads each item into the squaring
// register, and the phase update then loads its result register. Sample
// items walk the phases normal, free fall, impact, posture check and
// detected. A detected fall stays latched until a clear item returns the
// detector to normal. The throughput is set by the phase update stage, which
// commits one item each cycle while the result register is free or being
// drained. Stillness is judged on the mean of the last STILL_WINDOW
// |magnitude - 1g| deviations, kept in a shift line with a running sum.
// Configuration writes are registered before items see them. The limits for
// gyro_peak_min and still_threshold pass through one more register, since
// they are squared or scaled there.
// ----------------------------------------------------------------------------
module fall_detection_fsm
   import fds_pkg::*;
#(
   parameter int STILL_WINDOW    = 16,
   parameter int FREEFALL_FRAMES = 3,
   parameter int POSTURE_FRAMES  = 25
) (
   input  logic                  clock,
   input  logic                  reset,
   fds_req_if.sink               req_ch,
   fds_rsp_if.source             rsp_ch,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int FILL_W = $clog2(STILL_WINDOW + 1);
   localparam int SUM_W  = 16 + $clog2(STILL_WINDOW);
   localparam int LIM_W  = 16 + $clog2(STILL_WINDOW + 1);

   // configuration
   logic [15:0]      freefall_thr_ff;
   logic [15:0]      impact_thr_ff;
   logic [14:0]      gyro_peak_min_ff;
   logic [14:0]      posture_angle_ff;
   logic [15:0]      still_thr_ff;
   logic [15:0]      freefall_tmo_ff;
   logic [15:0]      impact_win_ff;
   logic [15:0]      posture_tmo_ff;
   logic [29:0]      gmin_sq_ff;
   logic [LIM_W-1:0] still_lim_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         freefall_thr_ff  <= 16'd1638;
         impact_thr_ff    <= 16'd10240;
         gyro_peak_min_ff <= 15'd3200;
         posture_angle_ff <= 15'd5760;
         still_thr_ff     <= 16'd410;
         freefall_tmo_ff  <= 16'd500;
         impact_win_ff    <= 16'd300;
         posture_tmo_ff   <= 16'd3000;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_FREEFALL_THR:  freefall_thr_ff  <= csr_wdata;
            CSR_IMPACT_THR:    impact_thr_ff    <= csr_wdata;
            CSR_GYRO_PEAK_MIN: gyro_peak_min_ff <= csr_wdata[14:0];
            CSR_POSTURE_ANGLE: posture_angle_ff <= csr_wdata[14:0];
            CSR_STILL_THR:     still_thr_ff     <= csr_wdata;
            CSR_FREEFALL_TMO:  freefall_tmo_ff  <= csr_wdata;
            CSR_IMPACT_WIN:    impact_win_ff    <= csr_wdata;
            CSR_POSTURE_TMO:   posture_tmo_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      gmin_sq_ff   <= 30'(gyro_peak_min_ff) * 30'(gyro_peak_min_ff);
      still_lim_ff <= LIM_W'(still_thr_ff) * LIM_W'(STILL_WINDOW);
   end

   // stage a: squares, absolute values, deviation
   logic        a_valid_ff;
   logic        a_func_ff;
   logic [15:0] a_mag_ff;
   logic [31:0] a_sqx_ff;
   logic [31:0] a_sqy_ff;
   logic [31:0] a_sqz_ff;
   logic [15:0] a_ang_ff;
   logic [15:0] a_dev_ff;
   logic [31:0] a_now_ff;

   logic        out_valid_ff;
   logic        out_fall_ff;
   logic [2:0]  out_phase_ff;

   logic        b_fire;
   logic        a_fire;
   logic [15:0] abs_gx, abs_gy, abs_gz, abs_roll, abs_pitch;

   assign b_fire = a_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !a_valid_ff || b_fire;
   assign a_fire = req_ch.valid && req_ch.ready;

   function automatic logic [15:0] abs16(input logic signed [15:0] v);
      logic [15:0] r;
      r = v[15] ? 16'(-v) : 16'(v);
      return r;
   endfunction

   assign abs_gx    = abs16(req_ch.gyro_x);
   assign abs_gy    = abs16(req_ch.gyro_y);
   assign abs_gz    = abs16(req_ch.gyro_z);
   assign abs_roll  = abs16(req_ch.roll_angle);
   assign abs_pitch = abs16(req_ch.pitch_angle);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         a_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (a_fire) begin
         a_func_ff <= req_ch.func;
         a_mag_ff  <= req_ch.accel_magnitude;
         a_sqx_ff  <= 32'(abs_gx) * 32'(abs_gx);
         a_sqy_ff  <= 32'(abs_gy) * 32'(abs_gy);
         a_sqz_ff  <= 32'(abs_gz) * 32'(abs_gz);
         a_ang_ff  <= (abs_roll > abs_pitch) ? abs_roll : abs_pitch;
         a_dev_ff  <= (req_ch.accel_magnitude >= ONE_G_Q12) ?
                      req_ch.accel_magnitude - ONE_G_Q12 :
                      ONE_G_Q12 - req_ch.accel_magnitude;
         a_now_ff  <= req_ch.time_ms;
      end
   end

   // stage b: phase update
   logic [2:0]        phase_ff, phase_in;
   logic [31:0]       start_ff, start_in;
   logic [3:0]        ff_cnt_ff, ff_cnt_in;
   logic [7:0]        pos_cnt_ff, pos_cnt_in;
   logic [31:0]       peak_ff, peak_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [15:0]       dev_line_ff [STILL_WINDOW];
   logic              detected;

   logic [31:0] gsq;
   logic [31:0] elapsed;
   logic [31:0] peak_max;
   logic        full;
   logic        still;

   assign gsq      = a_sqx_ff + a_sqy_ff + a_sqz_ff;
   assign elapsed  = a_now_ff - start_ff;
   assign peak_max = (gsq > peak_ff) ? gsq : peak_ff;
   assign full     = fill_ff == FILL_W'(STILL_WINDOW);

   always_comb begin
      phase_in   = phase_ff;
      start_in   = start_ff;
      ff_cnt_in  = ff_cnt_ff;
      pos_cnt_in = pos_cnt_ff;
      peak_in    = peak_ff;
      detected   = 1'b0;
      sum_in     = sum_ff - (full ? SUM_W'(dev_line_ff[STILL_WINDOW-1]) : SUM_W'(0))
                   + SUM_W'(a_dev_ff);
      fill_in    = full ? fill_ff : fill_ff + FILL_W'(1);
      still      = (fill_in == FILL_W'(STILL_WINDOW)) &&
                   (LIM_W'(sum_in) < still_lim_ff);
      if (a_func_ff == FUNC_CLEAR) begin
         phase_in   = PH_NORMAL;
         start_in   = '0;
         ff_cnt_in  = '0;
         pos_cnt_in = '0;
         peak_in    = '0;
         sum_in     = '0;
         fill_in    = '0;
      end else begin
         unique case (phase_ff)
            PH_NORMAL: begin
               if (a_mag_ff < freefall_thr_ff) begin
                  if (ff_cnt_ff != FREEFALL_CNT_MAX) ff_cnt_in = ff_cnt_ff + 4'd1;
                  if (ff_cnt_in >= 4'(FREEFALL_FRAMES)) begin
                     phase_in  = PH_FREEFALL;
                     start_in  = a_now_ff;
                     peak_in   = gsq;
                     ff_cnt_in = '0;
                  end
               end else begin
                  ff_cnt_in = '0;
               end
            end
            PH_FREEFALL: begin
               peak_in = peak_max;
               if (a_mag_ff > impact_thr_ff) begin
                  phase_in = PH_IMPACT;
                  start_in = a_now_ff;
               end else if (elapsed > 32'(freefall_tmo_ff)) begin
                  phase_in = PH_NORMAL;
               end
            end
            PH_IMPACT: begin
               peak_in = peak_max;
               if (elapsed >= 32'(impact_win_ff)) begin
                  if (peak_max < 32'(gmin_sq_ff)) begin
                     phase_in = PH_NORMAL;
                  end else begin
                     phase_in   = PH_POSTURE;
                     start_in   = a_now_ff;
                     pos_cnt_in = '0;
                  end
               end
            end
            PH_POSTURE: begin
               if (a_ang_ff > 16'(posture_angle_ff)) begin
                  if (pos_cnt_ff != POSTURE_CNT_MAX) pos_cnt_in = pos_cnt_ff + 8'd1;
               end else begin
                  pos_cnt_in = '0;
               end
               if (pos_cnt_in >= 8'(POSTURE_FRAMES) && still) begin
                  phase_in = PH_DETECTED;
                  detected = 1'b1;
               end else if (elapsed > 32'(posture_tmo_ff)) begin
                  phase_in = PH_NORMAL;
               end
            end
            PH_DETECTED: begin
               detected = 1'b1;
            end
            default: begin
               phase_in = PH_NORMAL;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_NORMAL;
         start_ff   <= '0;
         ff_cnt_ff  <= '0;
         pos_cnt_ff <= '0;
         peak_ff    <= '0;
         fill_ff    <= '0;
         sum_ff     <= '0;
      end else if (b_fire) begin
         phase_ff   <= phase_in;
         start_ff   <= start_in;
         ff_cnt_ff  <= ff_cnt_in;
         pos_cnt_ff <= pos_cnt_in;
         peak_ff    <= peak_in;
         fill_ff    <= fill_in;
         sum_ff     <= sum_in;
      end
   end

   // shift in the deviation on every sample transfer
   always_ff @(posedge clock) begin
      if (b_fire && a_func_ff == FUNC_SAMPLE) begin
         dev_line_ff[0] <= a_dev_ff;
         for (int i = 1; i < STILL_WINDOW; i++) begin
            dev_line_ff[i] <= dev_line_ff[i-1];
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (b_fire) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (b_fire) begin
         out_fall_ff  <= detected;
         out_phase_ff <= phase_in;
      end
   end

   assign rsp_ch.valid         = out_valid_ff;
   assign rsp_ch.fall_detected = out_fall_ff;
   assign rsp_ch.phase         = out_phase_ff;

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the fall detection state machine. A directed table
// covers field extremes, both item kinds, the free fall timeout, the impact
// window decision and a timestamp wrap. Random fall sequences (calm samples,
// low-g run, impact, spinning window, tilted and still posture, clear) then
// run under several register settings, mixed with random noise items. Every
// result is checked in order against its table verdict or a detector model.
// ----------------------------------------------------------------------------
module tb_top;
   import fds_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int STILL_WIN   = 16;
   localparam int FF_FRAMES   = 3;
   localparam int POST_FRAMES = 25;
   localparam int QUIET_LIMIT = 2000;
   localparam int PHASE_ITEMS = 75;
   localparam int DIR_N       = 23;

   typedef struct packed {
      logic               func;
      logic [15:0]        mag;
      logic signed [15:0] gx;
      logic signed [15:0] gy;
      logic signed [15:0] gz;
      logic signed [15:0] roll;
      logic signed [15:0] pitch;
      logic [31:0]        t;
   } sample_type;

   typedef struct packed {
      logic                fd;
      logic [PHASE_W-1:0]  phase;
   } verdict_type;

   typedef struct packed {
      sample_type  s;
      logic        typed;
      verdict_type v;
   } stim_row_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   fds_req_if req_ch ();
   fds_rsp_if rsp_ch ();

   fall_detection_fsm #(
      .STILL_WINDOW    (STILL_WIN),
      .FREEFALL_FRAMES (FF_FRAMES),
      .POSTURE_FRAMES  (POST_FRAMES)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #6 clock = ~clock;

   // detector model state
   logic [15:0]        cfg [8];
   logic [PHASE_W-1:0] m_phase;
   logic [31:0]        m_start;
   int                 m_ffcnt;
   int                 m_postcnt;
   logic [31:0]        m_peak;
   logic [15:0]        m_ring [STILL_WIN];
   int                 m_ptr;
   int                 m_fill;
   logic [31:0]        m_sum;

   verdict_type pending_results [$];
   int          errors = 0;
   int          items_sent = 0;
   int          burst_left = 0;
   int          quiet = 0;
   logic [31:0] now_ms;

   stim_row_type dir_tab [DIR_N] = '{
      '{'{FUNC_SAMPLE, 16'd4096, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 32'd0},
        1'b1, '{1'b0, PH_NORMAL}},
      '{'{FUNC_SAMPLE, 16'd65535, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sd23040,
          -16'sd23040, 32'd10}, 1'b1, '{1'b0, PH_NORMAL}},
      '{'{FUNC_SAMPLE, 16'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 32'd20},
        1'b1, '{1'b0, PH_NORMAL}},
      '{'{FUNC_SAMPLE, 16'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 32'd30},
        1'b1, '{1'b0, PH_NORMAL}},
      '{'{FUNC_SAMPLE, 16'd0, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sd0, 16'sd0, 32'd40},
        1'b1, '{1'b0, PH_FREEFALL}},
      '{'{FUNC_SAMPLE, 16'd1000, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 32'd100},
        1'b0, '0},
      '{'{FUNC_SAMPLE, 16'd1000, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 32'd541},
        1'b0, '0},
      '{'{FUNC_SAMPLE, 16'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 32'd600},
        1'b0, '0},
      '{'{FUNC_SAMPLE, 16'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 32'd610},
        1'b0, '0},
      '{'{FUNC_SAMPLE, 16'd0, 16'sh8000, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 32'd620},
        1'b0, '0},
      '{'{FUNC_SAMPLE, 16'd10241, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 32'd630},
        1'b1, '{1'b0, PH_IMPACT}},
      '{'{FUNC_SAMPLE, 16'd4096, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 32'd929},
        1'b0, '0},
      '{'{FUNC_SAMPLE, 16'd4096, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 32'd930},
        1'b0, '0},
      '{'{FUNC_SAMPLE, 16'd4096, 16'sd0, 16'sd0, 16'sd0, 16'sd23040, 16'sd0, 32'd950},
        1'b0, '0},
      '{'{FUNC_CLEAR, 16'hffff, 16'sh8000, 16'sh7fff, 16'sh8000, -16'sd23040,
          16'sd23040, 32'hffff_ffff}, 1'b1, '{1'b0, PH_NORMAL}},
      '{'{FUNC_SAMPLE, 16'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 32'hffff_fff0},
        1'b0, '0},
      '{'{FUNC_SAMPLE, 16'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 32'hffff_fff8},
        1'b0, '0},
      '{'{FUNC_SAMPLE, 16'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 32'd4},
        1'b0, '0},
      '{'{FUNC_SAMPLE, 16'd65535, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 32'd8},
        1'b0, '0},
      '{'{FUNC_SAMPLE, 16'd4096, 16'sd10, -16'sd10, 16'sd0, 16'sd0, 16'sd0, 32'd308},
        1'b0, '0},
      '{'{FUNC_SAMPLE, 16'd1638, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 32'd320},
        1'b0, '0},
      '{'{FUNC_SAMPLE, 16'd1637, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 32'd330},
        1'b0, '0},
      '{'{FUNC_CLEAR, 16'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 32'd0},
        1'b1, '{1'b0, PH_NORMAL}}
   };

   function automatic logic [16:0] abs17(logic signed [15:0] v);
      logic signed [16:0] w;
      w = v;
      return (w < 0) ? 17'(-w) : 17'(w);
   endfunction

   function automatic logic [31:0] square16(logic signed [15:0] v);
      logic [31:0] a;
      a = {15'd0, abs17(v)};
      return a * a;
   endfunction

   function automatic void clear_detector();
      m_phase   = PH_NORMAL;
      m_start   = '0;
      m_ffcnt   = 0;
      m_postcnt = 0;
      m_peak    = '0;
      m_ptr     = 0;
      m_fill    = 0;
      m_sum     = '0;
   endfunction

   function automatic void reset_detector();
      cfg[CSR_FREEFALL_THR]  = 16'd1638;
      cfg[CSR_IMPACT_THR]    = 16'd10240;
      cfg[CSR_GYRO_PEAK_MIN] = 16'd3200;
      cfg[CSR_POSTURE_ANGLE] = 16'd5760;
      cfg[CSR_STILL_THR]     = 16'd410;
      cfg[CSR_FREEFALL_TMO]  = 16'd500;
      cfg[CSR_IMPACT_WIN]    = 16'd300;
      cfg[CSR_POSTURE_TMO]   = 16'd3000;
      clear_detector();
   endfunction

   function automatic verdict_type detector_step(sample_type s);
      verdict_type r;
      logic [31:0] gsq;
      logic [31:0] elapsed;
      logic [31:0] min_sq;
      logic [16:0] ar;
      logic [16:0] ap;
      logic [16:0] ang;
      logic [15:0] dev;
      bit          still;
      r.fd = 1'b0;
      if (s.func == FUNC_CLEAR) begin
         clear_detector();
         r.phase = PH_NORMAL;
         return r;
      end
      gsq     = square16(s.gx) + square16(s.gy) + square16(s.gz);
      ar      = abs17(s.roll);
      ap      = abs17(s.pitch);
      ang     = (ar > ap) ? ar : ap;
      elapsed = s.t - m_start;
      min_sq  = {16'd0, cfg[CSR_GYRO_PEAK_MIN]} * {16'd0, cfg[CSR_GYRO_PEAK_MIN]};

      dev = (s.mag >= ONE_G_Q12) ? s.mag - ONE_G_Q12 : ONE_G_Q12 - s.mag;
      if (m_fill >= STILL_WIN) m_sum = m_sum - {16'd0, m_ring[m_ptr]};
      m_ring[m_ptr] = dev;
      m_sum = m_sum + {16'd0, dev};
      m_ptr = (m_ptr + 1) % STILL_WIN;
      if (m_fill < STILL_WIN) m_fill++;

      case (m_phase)
         PH_NORMAL: begin
            if (s.mag < cfg[CSR_FREEFALL_THR]) begin
               if (m_ffcnt < FREEFALL_CNT_MAX) m_ffcnt++;
               if (m_ffcnt >= FF_FRAMES) begin
                  m_phase = PH_FREEFALL;
                  m_start = s.t;
                  m_peak  = gsq;
                  m_ffcnt = 0;
               end
            end else begin
               m_ffcnt = 0;
            end
         end
         PH_FREEFALL: begin
            if (gsq > m_peak) m_peak = gsq;
            if (s.mag > cfg[CSR_IMPACT_THR]) begin
               m_phase = PH_IMPACT;
               m_start = s.t;
            end else if (elapsed > cfg[CSR_FREEFALL_TMO]) begin
               m_phase = PH_NORMAL;
            end
         end
         PH_IMPACT: begin
            if (gsq > m_peak) m_peak = gsq;
            if (elapsed >= cfg[CSR_IMPACT_WIN]) begin
               if (m_peak < min_sq) begin
                  m_phase = PH_NORMAL;
               end else begin
                  m_phase   = PH_POSTURE;
                  m_start   = s.t;
                  m_postcnt = 0;
               end
            end
         end
         PH_POSTURE: begin
            if (ang > cfg[CSR_POSTURE_ANGLE]) begin
               if (m_postcnt < POSTURE_CNT_MAX) m_postcnt++;
            end else begin
               m_postcnt = 0;
            end
            still = (m_fill >= STILL_WIN) &&
                    (m_sum < {16'd0, cfg[CSR_STILL_THR]} * STILL_WIN);
            if (m_postcnt >= POST_FRAMES && still) begin
               m_phase = PH_DETECTED;
               r.fd    = 1'b1;
            end else if (elapsed > cfg[CSR_POSTURE_TMO]) begin
               m_phase = PH_NORMAL;
            end
         end
         PH_DETECTED: begin
            r.fd = 1'b1;
         end
         default: begin
            m_phase = PH_NORMAL;
         end
      endcase
      r.phase = m_phase;
      return r;
   endfunction

   function automatic logic [15:0] calm_mag(bit loud);
      int span;
      if (loud) span = 20000;
      else if (cfg[CSR_STILL_THR] == 0) span = 0;
      else if (cfg[CSR_STILL_THR] > 4095) span = 4095;
      else span = int'(cfg[CSR_STILL_THR]) - 1;
      if ($urandom_range(0, 1) != 0) return 16'(int'(ONE_G_Q12) + $urandom_range(0, span));
      return 16'(int'(ONE_G_Q12) - int'($urandom_range(0, span)));
   endfunction

   function automatic sample_type make_sample(logic [15:0] mag, bit spin, bit tilt);
      sample_type s;
      int         thr;
      int         hi;
      int         cap;
      int         a;
      int         b;
      s.func = FUNC_SAMPLE;
      s.mag  = mag;
      s.gx   = spin ? 16'($urandom) : 16'(int'($urandom_range(0, 800)) - 400);
      s.gy   = spin ? 16'($urandom) : 16'(int'($urandom_range(0, 800)) - 400);
      s.gz   = spin ? 16'($urandom) : 16'(int'($urandom_range(0, 800)) - 400);
      thr = int'(cfg[CSR_POSTURE_ANGLE]);
      hi  = (thr < 23040) ? 23040 : 32767;
      cap = (thr < 23040) ? thr : 23040;
      if (tilt) a = (thr < hi) ? int'($urandom_range(thr + 1, hi)) : hi;
      else a = $urandom_range(0, cap);
      b = $urandom_range(0, cap);
      if ($urandom_range(0, 1) != 0) a = -a;
      if ($urandom_range(0, 1) != 0) b = -b;
      if ($urandom_range(0, 1) != 0) begin
         s.roll  = 16'(a);
         s.pitch = 16'(b);
      end else begin
         s.roll  = 16'(b);
         s.pitch = 16'(a);
      end
      s.t = now_ms;
      return s;
   endfunction

   task automatic send_sample(input sample_type s, input bit typed,
                              input verdict_type typed_v);
      verdict_type v;
      int          gap;
      if (burst_left <= 0) begin
         burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         repeat (gap) begin
            req_ch.valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_ch.valid           <= 1'b1;
      req_ch.func            <= s.func;
      req_ch.accel_magnitude <= s.mag;
      req_ch.gyro_x          <= s.gx;
      req_ch.gyro_y          <= s.gy;
      req_ch.gyro_z          <= s.gz;
      req_ch.roll_angle      <= s.roll;
      req_ch.pitch_angle     <= s.pitch;
      req_ch.time_ms         <= s.t;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      burst_left--;
      items_sent++;
      v = detector_step(s);
      pending_results.push_back(typed ? typed_v : v);
   endtask

   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      burst_left = 0;
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [15:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      if (idx == CSR_GYRO_PEAK_MIN || idx == CSR_POSTURE_ANGLE) cfg[idx] = {1'b0, val[14:0]};
      else cfg[idx] = val;
   endtask

   task automatic program_setting(input int k);
      logic [15:0] vals [8];
      case (k)
         1: begin
            vals[CSR_FREEFALL_THR]  = 16'd1638;
            vals[CSR_IMPACT_THR]    = 16'd10240;
            vals[CSR_GYRO_PEAK_MIN] = 16'd3200 | 16'h8000;
            vals[CSR_POSTURE_ANGLE] = 16'd5760 | 16'h8000;
            vals[CSR_STILL_THR]     = 16'd410;
            vals[CSR_FREEFALL_TMO]  = 16'd500;
            vals[CSR_IMPACT_WIN]    = 16'd300;
            vals[CSR_POSTURE_TMO]   = 16'd3000;
         end
         2: foreach (vals[i]) vals[i] = 16'h0000;
         3: foreach (vals[i]) vals[i] = 16'hffff;
         5: foreach (vals[i]) vals[i] = 16'($urandom);
         default: begin
            vals[CSR_FREEFALL_THR]  = 16'($urandom_range(500, 3000));
            vals[CSR_IMPACT_THR]    = 16'($urandom_range(6000, 20000));
            vals[CSR_GYRO_PEAK_MIN] = 16'($urandom_range(0, 6000));
            vals[CSR_POSTURE_ANGLE] = 16'($urandom_range(0, 15000));
            vals[CSR_STILL_THR]     = 16'($urandom_range(100, 3000));
            vals[CSR_FREEFALL_TMO]  = 16'($urandom_range(k == 6 ? 0 : 50, k == 6 ? 50 : 1500));
            vals[CSR_IMPACT_WIN]    = 16'($urandom_range(0, k == 6 ? 50 : 600));
            vals[CSR_POSTURE_TMO]   = 16'($urandom_range(k == 6 ? 0 : 200, k == 6 ? 50 : 5000));
         end
      endcase
      for (int i = 0; i < 8; i++) write_csr(CSR_IDX_W'(i), vals[i]);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic noise_items(input int n);
      sample_type s;
      repeat (n) begin
         if ($urandom_range(0, 7) == 0) now_ms = $urandom;
         else now_ms += $urandom_range(0, 200);
         s = make_sample(16'($urandom), 1'b1, $urandom_range(0, 1) != 0);
         if ($urandom_range(0, 3) == 0) s.roll = 16'($urandom);
         if ($urandom_range(0, 3) == 0) s.pitch = 16'($urandom);
         if ($urandom_range(0, 9) == 0) s.func = FUNC_CLEAR;
         send_sample(s, 1'b0, '0);
      end
   endtask

   task automatic fall_sequence();
      sample_type  s;
      int          n;
      int          step;
      bit          loud;
      logic [15:0] m;
      logic [31:0] t0;
      if ($urandom_range(0, 7) == 0) now_ms = $urandom;
      if ($urandom_range(0, 2) == 0) begin
         s = make_sample(16'($urandom), 1'b1, 1'b0);
         s.func = FUNC_CLEAR;
         send_sample(s, 1'b0, '0);
      end
      loud = ($urandom_range(0, 4) == 0);

      repeat ($urandom_range(0, 18)) begin
         now_ms += $urandom_range(5, 40);
         send_sample(make_sample(calm_mag(loud), 1'b0, 1'b0), 1'b0, '0);
      end

      step = int'(cfg[CSR_FREEFALL_TMO]) / 8 + 1;
      repeat (FF_FRAMES + $urandom_range(0, 3)) begin
         now_ms += $urandom_range(1, step);
         m = (cfg[CSR_FREEFALL_THR] == 0) ? 16'd0
                                          : 16'($urandom_range(0, cfg[CSR_FREEFALL_THR] - 1));
         send_sample(make_sample(m, 1'b1, 1'b0), 1'b0, '0);
      end
      if ($urandom_range(0, 5) == 0) begin
         now_ms += cfg[CSR_FREEFALL_TMO] + $urandom_range(1, 40);
         send_sample(make_sample(calm_mag(loud), 1'b0, 1'b0), 1'b0, '0);
      end

      now_ms += $urandom_range(1, step);
      m = (cfg[CSR_IMPACT_THR] == 16'hffff) ? 16'hffff
                                             : 16'($urandom_range(cfg[CSR_IMPACT_THR] + 1, 65535));
      send_sample(make_sample(m, 1'b1, 1'b0), 1'b0, '0);

      t0   = now_ms;
      n    = 0;
      step = int'(cfg[CSR_IMPACT_WIN]) / 6 + 1;
      while (32'(now_ms - t0) < cfg[CSR_IMPACT_WIN] && n < 40) begin
         now_ms += $urandom_range(1, step);
         send_sample(make_sample(calm_mag(loud), $urandom_range(0, 3) != 0, 1'b0), 1'b0, '0);
         n++;
      end

      step = int'(cfg[CSR_POSTURE_TMO]) / 60 + 1;
      repeat (POST_FRAMES + $urandom_range(0, 12)) begin
         now_ms += $urandom_range(1, step);
         send_sample(make_sample(calm_mag(loud), 1'b0, $urandom_range(0, 15) != 0),
                     1'b0, '0);
      end

      repeat ($urandom_range(0, 5)) begin
         now_ms += $urandom_range(1, 100);
         send_sample(make_sample(16'($urandom), 1'b1, 1'b1), 1'b0, '0);
      end
      if ($urandom_range(0, 3) != 0) begin
         s = make_sample(16'($urandom), 1'b1, 1'b1);
         s.func = FUNC_CLEAR;
         send_sample(s, 1'b0, '0);
      end
   endtask

   // response side: ready follows a randomly chosen stall pattern
   initial begin : rsp_stall
      int mode;
      rsp_ch.ready = 1'b0;
      forever begin
         mode = $urandom_range(0, 3);
         repeat ($urandom_range(20, 200)) begin
            @(posedge clock);
            case (mode)
               0: rsp_ch.ready <= 1'b1;
               1: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
               2: rsp_ch.ready <= ~rsp_ch.ready;
               default: rsp_ch.ready <= ($urandom_range(0, 7) == 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin
      verdict_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_results.size() == 0) begin
            $error("unexpected result transfer: fall_detected %0d phase %0d",
                   rsp_ch.fall_detected, rsp_ch.phase);
            errors++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_ch.fall_detected !== want.fd) begin
               $error("fall_detected: expected %0d, got %0d", want.fd, rsp_ch.fall_detected);
               errors++;
            end
            if (rsp_ch.phase !== want.phase) begin
               $error("phase: expected %0d, got %0d", want.phase, rsp_ch.phase);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet <= 0;
      end else if (quiet >= QUIET_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   initial begin : stimulus
      int phase_end;
      reset                  = 1'b1;
      csr_we                 = 1'b0;
      csr_index              = CSR_FREEFALL_THR;
      csr_wdata              = '0;
      req_ch.valid           = 1'b0;
      req_ch.func            = FUNC_SAMPLE;
      req_ch.accel_magnitude = '0;
      req_ch.gyro_x          = '0;
      req_ch.gyro_y          = '0;
      req_ch.gyro_z          = '0;
      req_ch.roll_angle      = '0;
      req_ch.pitch_angle     = '0;
      req_ch.time_ms         = '0;
      reset_detector();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_tab[i]) send_sample(dir_tab[i].s, dir_tab[i].typed, dir_tab[i].v);
      now_ms = 32'd1000;

      for (int k = 0; k < 7; k++) begin
         if (k != 0) begin
            wait_idle();
            program_setting(k);
         end
         phase_end = items_sent + PHASE_ITEMS;
         while (items_sent < phase_end) begin
            if ($urandom_range(0, 3) != 0) fall_sequence();
            else noise_items($urandom_range(3, 15));
         end
      end
      wait_idle();

      if (errors == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end

endmodule

FILE: sim.f
hdl/fds_pkg.sv
hdl/fds_req_if.sv
hdl/fds_rsp_if.sv
hdl/fall_detection_fsm.sv
tb/tb_top.sv
